// ===== src/alu_rs_pkg.sv =====
// Shared types and constants for the ALU reservation station.
// Used by the entry, the ALU and the top level; no dependencies.
package alu_rs_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W = 4;
	localparam int WAIT_W = 4;
	localparam int TAG_W = 3;

	// A wait code at or above the tag count marks an operand as ready.
	localparam int TAG_COUNT = 8;
	localparam logic [WAIT_W-1:0] WAIT_READY = WAIT_W'(TAG_COUNT);

	localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
	localparam logic [OP_W-1:0] OP_SLL   = 4'd2;
	localparam logic [OP_W-1:0] OP_SLT   = 4'd3;
	localparam logic [OP_W-1:0] OP_SLTU  = 4'd4;
	localparam logic [OP_W-1:0] OP_XOR   = 4'd5;
	localparam logic [OP_W-1:0] OP_SRL   = 4'd6;
	localparam logic [OP_W-1:0] OP_SRA   = 4'd7;
	localparam logic [OP_W-1:0] OP_OR    = 4'd8;
	localparam logic [OP_W-1:0] OP_AND   = 4'd9;
	localparam logic [OP_W-1:0] OP_AUIPC = 4'd10;
	localparam logic [OP_W-1:0] OP_LUI   = 4'd11;

	typedef struct packed {
		logic                     issue_valid;
		logic [OP_W-1:0]          issue_op;
		logic signed [DATA_W-1:0] issue_a;
		logic signed [DATA_W-1:0] issue_b;
		logic [WAIT_W-1:0]        issue_wait_a;
		logic [WAIT_W-1:0]        issue_wait_b;
		logic [TAG_W-1:0]         issue_tag;
		logic [DATA_W-1:0]        issue_pc;
		logic                     bcast_valid;
		logic [TAG_W-1:0]         bcast_tag;
		logic signed [DATA_W-1:0] bcast_value;
		logic                     bus_free;
	} item_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [WAIT_W-1:0] wait_a;
		logic [WAIT_W-1:0] wait_b;
		logic [TAG_W-1:0]  tag;
		logic [DATA_W-1:0] pc;
	} held_t;

	typedef struct packed {
		logic                     result_valid;
		logic [TAG_W-1:0]         result_tag;
		logic signed [DATA_W-1:0] result_value;
		logic                     bus_claim;
		logic                     busy_res;
	} res_t;

endpackage

// ===== src/alu_rs_alu.sv =====
// RV32I integer ALU used by the reservation station.
// Depends on alu_rs_pkg for the op codes.
module alu_rs_alu import alu_rs_pkg::*; (
	input  logic [OP_W-1:0]   op,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	input  logic [DATA_W-1:0] pc,
	output logic [DATA_W-1:0] y
);

	logic [4:0] sh;

	assign sh = b[4:0];

	always_comb begin
		unique case (op)
			OP_ADD:   y = a + b;
			OP_SUB:   y = a - b;
			OP_SLL:   y = a << sh;
			OP_SLT:   y = DATA_W'($signed(a) < $signed(b));
			OP_SLTU:  y = DATA_W'(a < b);
			OP_XOR:   y = a ^ b;
			OP_SRL:   y = a >> sh;
			OP_SRA:   y = $unsigned($signed(a) >>> sh);
			OP_OR:    y = a | b;
			OP_AND:   y = a & b;
			OP_AUIPC: y = pc + b;
			OP_LUI:   y = b;
			default:  y = '0;
		endcase
	end

endmodule

// ===== src/alu_rs_entry.sv =====
// Held entry of the reservation station: operand capture, execute and free.
// Depends on alu_rs_pkg and instantiates alu_rs_alu.
module alu_rs_entry import alu_rs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	output res_t  res,
	output logic  held_valid
);

	logic              held_valid_q;
	held_t             held_q;
	held_t             held_n;
	logic              valid_n;
	logic              ready_a;
	logic              ready_b;
	logic              exec;
	logic              claim;
	logic              cap_a;
	logic              cap_b;
	logic [DATA_W-1:0] alu_y;

	alu_rs_alu u_alu (
		.op (held_q.op),
		.a  (held_q.a),
		.b  (held_q.b),
		.pc (held_q.pc),
		.y  (alu_y)
	);

	assign ready_a = held_q.wait_a >= WAIT_READY;
	assign ready_b = held_q.wait_b >= WAIT_READY;
	assign exec = held_valid_q && ready_a && ready_b;
	assign claim = exec && item.bus_free;

	assign cap_a = held_valid_q && !ready_a && item.bcast_valid &&
		({1'b0, item.bcast_tag} == held_q.wait_a);
	assign cap_b = held_valid_q && !ready_b && item.bcast_valid &&
		({1'b0, item.bcast_tag} == held_q.wait_b);

	always_comb begin
		held_n = held_q;
		if (cap_a) begin
			held_n.wait_a = WAIT_READY;
			held_n.a = item.bcast_value;
		end
		if (cap_b) begin
			held_n.wait_b = WAIT_READY;
			held_n.b = item.bcast_value;
		end
		// A new issue overwrites the entry, including any capture above.
		if (item.issue_valid) begin
			held_n.op = item.issue_op;
			held_n.a = item.issue_a;
			held_n.b = item.issue_b;
			held_n.wait_a = item.issue_wait_a;
			held_n.wait_b = item.issue_wait_b;
			held_n.tag = item.issue_tag;
			held_n.pc = item.issue_pc;
		end
	end

	assign valid_n = item.issue_valid || (held_valid_q && !claim);

	always_comb begin
		res.result_valid = exec;
		res.result_tag = exec ? held_q.tag : '0;
		res.result_value = exec ? alu_y : '0;
		res.bus_claim = claim;
		res.busy_res = valid_n;
	end

	assign held_valid = held_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (step) begin
			held_valid_q <= valid_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			held_q <= held_n;
		end
	end

endmodule

// ===== src/alu_reservation_station_top.sv =====
// Top level of the single-entry ALU reservation station.
// Depends on alu_rs_pkg and instantiates alu_rs_entry.
//
// One input transfer on the in channel carries one processor cycle's worth of
// station inputs: an optional issue, an optional commit-bus broadcast and the
// bus-free flag. Each input transfer yields exactly one output transfer on the
// out channel with the execute result, bus claim and busy flag of that cycle.
// Inputs land in an input register; from there the held entry, its operand
// capture and the ALU evaluate it and the outcome is written to the output
// register, from which it transfers on the out channel. Throughput is one
// item per cycle while out_stall is low; the only loop is the held entry,
// which is updated by one step of logic per item.
// When out_stall is high the output register holds its result; the input
// register keeps taking a transfer until it is full, then in_stall rises in
// the same cycle. Reset empties both registers and the station.
module alu_reservation_station_top import alu_rs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     issue_valid,
	input  logic [OP_W-1:0]          issue_op,
	input  logic signed [DATA_W-1:0] issue_a,
	input  logic signed [DATA_W-1:0] issue_b,
	input  logic [WAIT_W-1:0]        issue_wait_a,
	input  logic [WAIT_W-1:0]        issue_wait_b,
	input  logic [TAG_W-1:0]         issue_tag,
	input  logic [DATA_W-1:0]        issue_pc,
	input  logic                     bcast_valid,
	input  logic [TAG_W-1:0]         bcast_tag,
	input  logic signed [DATA_W-1:0] bcast_value,
	input  logic                     bus_free,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     result_valid,
	output logic [TAG_W-1:0]         result_tag,
	output logic signed [DATA_W-1:0] result_value,
	output logic                     bus_claim,
	output logic                     busy_res
);

	item_t item_in;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  adv;
	logic  held_valid;

	always_comb begin
		item_in.issue_valid = issue_valid;
		item_in.issue_op = issue_op;
		item_in.issue_a = issue_a;
		item_in.issue_b = issue_b;
		item_in.issue_wait_a = issue_wait_a;
		item_in.issue_wait_b = issue_wait_b;
		item_in.issue_tag = issue_tag;
		item_in.issue_pc = issue_pc;
		item_in.bcast_valid = bcast_valid;
		item_in.bcast_tag = bcast_tag;
		item_in.bcast_value = bcast_value;
		item_in.bus_free = bus_free;
	end

	// The held item moves on when the output register is empty or drains now.
	assign adv = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	alu_rs_entry u_entry (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.item       (item_s1),
		.res        (res),
		.held_valid (held_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= item_in;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign result_valid = res_s2.result_valid;
	assign result_tag = res_s2.result_tag;
	assign result_value = res_s2.result_value;
	assign bus_claim = res_s2.bus_claim;
	assign busy_res = res_s2.busy_res;

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.result_valid |->
		res_s2.result_tag == '0 && res_s2.result_value == '0)
		else $error("result fields not zero without execution");

	a_claim_exec: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.bus_claim |-> res_s2.result_valid)
		else $error("bus claimed without an executed entry");

	a_busy_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.busy_res == held_valid)
		else $error("busy flag disagrees with the held entry");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled while the pipeline can move");

endmodule
